FILE: rtl/lpt_pkg.sv
`default_nettype none

package lpt_pkg;

  localparam int unsigned CountWidth = 13;
  localparam int unsigned RegWidth   = 13;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned PhaseWidth = 3;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Press phase codes, as reported on the result channel
  localparam logic [PhaseWidth-1:0] PhIdle     = 3'd0;
  localparam logic [PhaseWidth-1:0] PhDebounce = 3'd1;
  localparam logic [PhaseWidth-1:0] PhShort    = 3'd2;
  localparam logic [PhaseWidth-1:0] PhLong     = 3'd3;
  localparam logic [PhaseWidth-1:0] PhArmed    = 3'd4;
  localparam logic [PhaseWidth-1:0] PhWait     = 3'd5;

  // Register indexes on the configuration port
  localparam logic [CfgIdxWidth-1:0] RegDebounce      = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegShortWindow   = 4'd1;
  localparam logic [CfgIdxWidth-1:0] RegLongWindow    = 4'd2;
  localparam logic [CfgIdxWidth-1:0] RegUnintentional = 4'd3;

  localparam logic [RegWidth-1:0] DebounceReset      = 13'd100;
  localparam logic [RegWidth-1:0] ShortWindowReset   = 13'd500;
  localparam logic [RegWidth-1:0] LongWindowReset    = 13'd1000;
  localparam logic [RegWidth-1:0] UnintentionalReset = 13'd4000;

  localparam int unsigned CmpWidth = CountWidth + RegWidth;

  typedef struct packed {
    logic [RegWidth-1:0] debounce_ticks;
    logic [RegWidth-1:0] short_window_ticks;
    logic [RegWidth-1:0] long_window_ticks;
    logic [RegWidth-1:0] unintentional_ticks;
  } cfg_t;

  typedef struct packed {
    logic                  power_on;
    logic                  power_toggled;
    logic [PhaseWidth-1:0] press_phase;
  } result_t;

  // Window length as compared against the counter: at least 1, at most CountMax
  function automatic logic [CountWidth-1:0] window_limit(input logic [RegWidth-1:0] w);
    logic [CmpWidth-1:0] wx;
    logic [CmpWidth-1:0] mx;
    logic [CmpWidth-1:0] lim;
    wx = CmpWidth'(w);
    mx = CmpWidth'(CountMax);
    if (wx == '0) begin
      lim = CmpWidth'(1);
    end else if (wx > mx) begin
      lim = mx;
    end else begin
      lim = wx;
    end
    return lim[CountWidth-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/long_press_power_toggle_top.sv
// Long-press power toggle.
// Input channel: one transfer per millisecond tick carrying button_pressed_i,
// qualified by in_valid_i and accepted when in_stall_o is low. Every accepted
// tick yields exactly one result transfer (power_on_o, power_toggled_o,
// press_phase_o) on the output channel, qualified by out_valid_o and taken
// when out_stall_i is low.
// The registered result appears in the cycle after a tick is accepted. A tick
// can be accepted every cycle when not stalled; the phase, counter and power
// state update together and a single output register holds the result.
// When the receiver stalls, the output register holds its result and
// in_stall_o rises while it is full, so no tick is taken until the result
// leaves; a new tick may enter in the same cycle the old result is taken.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes one of
// the four window registers; cfg_ready_o is always high. Write only while
// the block is idle.
// Reset: phase idle, counter zero, power off, window registers at their
// defaults (100, 500, 1000, 4000 ticks), output register empty.
`default_nettype none

module long_press_power_toggle_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic                            button_pressed_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            power_on_o,
  output      logic                            power_toggled_o,
  output      logic [lpt_pkg::PhaseWidth-1:0]  press_phase_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [lpt_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [lpt_pkg::RegWidth-1:0]    cfg_data_i
);

  lpt_pkg::cfg_t    cfg;
  lpt_pkg::result_t result;
  lpt_pkg::result_t res_q;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  lpt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lpt_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .button_pressed_i(button_pressed_i),
    .cfg_i           (cfg),
    .result_o        (result)
  );

  // hold while stalled, load on each accepted tick
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign power_on_o      = res_q.power_on;
  assign power_toggled_o = res_q.power_toggled;
  assign press_phase_o   = res_q.press_phase;

endmodule

`default_nettype wire

FILE: rtl/lpt_cfg.sv
`default_nettype none

module lpt_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [lpt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [lpt_pkg::RegWidth-1:0]     cfg_data_i,
  output lpt_pkg::cfg_t                         cfg_o
);

  lpt_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks      <= lpt_pkg::DebounceReset;
      cfg_q.short_window_ticks  <= lpt_pkg::ShortWindowReset;
      cfg_q.long_window_ticks   <= lpt_pkg::LongWindowReset;
      cfg_q.unintentional_ticks <= lpt_pkg::UnintentionalReset;
    end else if (cfg_valid_i) begin
      // drop writes to unknown indexes
      case (cfg_index_i)
        lpt_pkg::RegDebounce:      cfg_q.debounce_ticks      <= cfg_data_i;
        lpt_pkg::RegShortWindow:   cfg_q.short_window_ticks  <= cfg_data_i;
        lpt_pkg::RegLongWindow:    cfg_q.long_window_ticks   <= cfg_data_i;
        lpt_pkg::RegUnintentional: cfg_q.unintentional_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/lpt_core.sv
`default_nettype none

module lpt_core (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire logic      button_pressed_i,
  input  wire lpt_pkg::cfg_t cfg_i,
  output lpt_pkg::result_t result_o
);

  logic [lpt_pkg::PhaseWidth-1:0] phase_q, phase_d;
  logic [lpt_pkg::CountWidth-1:0] count_q, count_d;
  logic                           power_q, power_d;
  logic                           toggled;

  logic [lpt_pkg::RegWidth-1:0]   win;
  logic [lpt_pkg::CountWidth-1:0] lim;
  logic [lpt_pkg::CountWidth-1:0] count_inc;
  logic                           win_done;

  always_comb begin
    case (phase_q)
      lpt_pkg::PhDebounce: win = cfg_i.debounce_ticks;
      lpt_pkg::PhShort:    win = cfg_i.short_window_ticks;
      lpt_pkg::PhLong:     win = cfg_i.long_window_ticks;
      default:             win = cfg_i.unintentional_ticks;
    endcase
  end

  assign lim       = lpt_pkg::window_limit(win);
  // saturate the held-tick count
  assign count_inc = (count_q == lpt_pkg::CountMax) ? count_q : count_q + 1'b1;
  assign win_done  = (count_inc >= lim);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    power_d = power_q;
    toggled = 1'b0;
    case (phase_q)
      lpt_pkg::PhDebounce, lpt_pkg::PhShort, lpt_pkg::PhLong: begin
        if (!button_pressed_i) begin
          phase_d = lpt_pkg::PhIdle;
          count_d = '0;
        end else if (win_done) begin
          phase_d = phase_q + 1'b1;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      lpt_pkg::PhArmed: begin
        if (!button_pressed_i) begin
          power_d = ~power_q;
          toggled = 1'b1;
          phase_d = lpt_pkg::PhIdle;
          count_d = '0;
        end else if (win_done) begin
          phase_d = lpt_pkg::PhWait;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      lpt_pkg::PhWait: begin
        if (!button_pressed_i) begin
          phase_d = lpt_pkg::PhIdle;
        end
        count_d = '0;
      end
      default: begin
        phase_d = button_pressed_i ? lpt_pkg::PhDebounce : lpt_pkg::PhIdle;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpt_pkg::PhIdle;
      count_q <= '0;
      power_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      power_q <= power_d;
    end
  end

  assign result_o.power_on      = power_d;
  assign result_o.power_toggled = toggled;
  assign result_o.press_phase   = phase_d;

endmodule

`default_nettype wire
